// ----- sv/actr_pkg.sv -----
package actr_pkg;

	localparam logic [31:0] GEN_MULT = 32'h6C078965;
	localparam int          RK_WORDS = 44;
	localparam int          RK_ROWS  = RK_WORDS / 4;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEED,
		ST_ROLL,
		ST_EMIT,
		ST_EXPAND,
		ST_RK_RD,
		ST_ROUND,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		CFG_KEY_SEED,
		CFG_KEY_ROLLS,
		CFG_CTR_SEED,
		CFG_CTR_ROLLS
	} cfg_idx_t;

	typedef struct packed {
		logic       load;
		logic       derive;
		logic       gen_seed;
		logic       gen_draw;
		logic       gen_emit;
		logic       gen_clr;
		logic       exp_step;
		logic       rk_rd;
		logic [3:0] rk_round;
		logic       round;
		logic       finish;
		logic       take_out;
	} cmd_t;

	typedef struct packed {
		logic       need_derive;
		logic [4:0] gen_cnt;
		logic [5:0] exp_idx;
		logic       out_busy;
	} sts_t;

	function automatic logic [7:0] sbox(input logic [7:0] x);
		logic [7:0] t [256];
		t = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
		return t[x];
	endfunction

	function automatic logic [7:0] rcon(input logic [3:0] i);
		unique case (i)
			4'd0: return 8'h01;
			4'd1: return 8'h02;
			4'd2: return 8'h04;
			4'd3: return 8'h08;
			4'd4: return 8'h10;
			4'd5: return 8'h20;
			4'd6: return 8'h40;
			4'd7: return 8'h80;
			4'd8: return 8'h1b;
			4'd9: return 8'h36;
			default: return 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] xt(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

endpackage

// ----- sv/actr_ctrl.sv -----
module actr_ctrl
	import actr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_restart,
	output logic in_ready,
	input  logic out_ready,
	input  logic [3:0] key_rolls,
	input  logic [3:0] ctr_rolls,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_nx;
	logic   gen_sel_q, gen_sel_nx;
	logic [3:0] rnd_q, rnd_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			gen_sel_q <= 1'b0;
			rnd_q     <= '0;
		end else begin
			state_q   <= state_nx;
			gen_sel_q <= gen_sel_nx;
			rnd_q     <= rnd_nx;
		end
	end

	logic [4:0] draws;
	assign draws = {(gen_sel_q ? ctr_rolls : key_rolls), 1'b1};

	always_comb begin
		state_nx   = state_q;
		gen_sel_nx = gen_sel_q;
		rnd_nx     = rnd_q;
		cmd        = '0;
		in_ready   = 1'b0;
		cmd.take_out = out_ready;
		cmd.derive   = gen_sel_q;
		cmd.rk_round = rnd_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load    = 1'b1;
					cmd.gen_clr = 1'b1;
					gen_sel_nx  = 1'b0;
					rnd_nx      = '0;
					state_nx    = (in_restart || sts.need_derive) ? ST_SEED : ST_RK_RD;
				end
			end
			// one seed word per cycle
			ST_SEED: begin
				cmd.gen_seed = 1'b1;
				if (sts.gen_cnt == 5'd3) begin
					cmd.gen_clr = 1'b1;
					state_nx    = ST_ROLL;
				end
			end
			ST_ROLL: begin
				cmd.gen_draw = 1'b1;
				if (sts.gen_cnt == draws) begin
					cmd.gen_clr = 1'b1;
					state_nx    = ST_EMIT;
				end
			end
			ST_EMIT: begin
				cmd.gen_emit = 1'b1;
				if (sts.gen_cnt == 5'd15) begin
					cmd.gen_clr = 1'b1;
					if (gen_sel_q) state_nx = ST_EXPAND;
					else begin
						gen_sel_nx = 1'b1;
						state_nx   = ST_SEED;
					end
				end
			end
			ST_EXPAND: begin
				cmd.exp_step = 1'b1;
				if (sts.exp_idx == 6'(RK_WORDS - 1)) state_nx = ST_RK_RD;
			end
			ST_RK_RD: begin
				cmd.rk_rd = 1'b1;
				state_nx  = ST_ROUND;
			end
			ST_ROUND: begin
				cmd.round = 1'b1;
				cmd.rk_rd = (rnd_q != 4'd10);
				cmd.rk_round = rnd_q + 4'd1;
				rnd_nx = rnd_q + 4'd1;
				if (rnd_q == 4'd10) state_nx = ST_OUT;
			end
			ST_OUT: begin
				if (!sts.out_busy || out_ready) begin
					cmd.finish = 1'b1;
					state_nx   = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> state_q == ST_IDLE)
		else $error("finish did not return to idle");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND) |-> rnd_q <= 4'd10)
		else $error("round count overrun");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXPAND && state_nx == ST_RK_RD) |-> gen_sel_q)
		else $error("expand before counter derived");

endmodule

// ----- sv/actr_dp.sv -----
module actr_dp
	import actr_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  cmd_t         cmd,
	output sts_t         sts,
	input  logic [31:0]  key_seed,
	input  logic [31:0]  ctr_seed,
	input  logic [63:0]  data_high,
	input  logic [63:0]  data_low,
	input  logic [4:0]   byte_count,
	output logic         out_valid,
	output logic [63:0]  result_high,
	output logic [63:0]  result_low,
	output logic [4:0]   result_count
);

	logic [31:0] g_q [4];
	logic [4:0]  gcnt_q;
	logic [127:0] key_q, ctr_q, st_q, data_q;
	logic [4:0]  cnt_q;
	logic        kv_q;
	logic [5:0]  ei_q;
	logic [127:0] rk_mem [RK_ROWS];
	logic [31:0] w_q [4];
	logic [127:0] rk_rd_q;
	logic [31:0] rk_wr;

	// generator: seeding shifts in one word per cycle
	logic [31:0] seed, sp, sn, dt, dn;
	assign seed = cmd.derive ? ctr_seed : key_seed;
	assign sp = (gcnt_q == 5'd0) ? seed : g_q[3];
	assign sn = GEN_MULT * (sp ^ (sp >> 30)) + {30'd0, gcnt_q[1:0]} + 32'd1;
	always_comb begin
		dt = g_q[0] ^ (g_q[0] << 11);
		dt = dt ^ (dt >> 8);
		dn = dt ^ g_q[3] ^ (g_q[3] >> 19);
	end

	// key expansion
	logic [31:0] kt;
	always_comb begin
		kt = w_q[3];
		if (ei_q[1:0] == 2'd0)
			kt = {sbox(w_q[3][23:16]) ^ rcon(4'(ei_q[5:2] - 4'd1)), sbox(w_q[3][15:8]),
				sbox(w_q[3][7:0]), sbox(w_q[3][31:24])};
	end
	assign rk_wr = (ei_q < 6'd4) ? key_q[127 - 32*ei_q[1:0] -: 32] : (w_q[0] ^ kt);

	// round
	logic [7:0] sb [16];
	logic [7:0] mc [16];
	logic [127:0] rk_now, rnd_out;
	assign rk_now = rk_rd_q;
	always_comb begin
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				sb[4*c+r] = sbox(st_q[127 - 8*(4*((c+r)%4)+r) -: 8]);
		for (int c = 0; c < 4; c++) begin
			mc[4*c]   = sb[4*c]   ^ (sb[4*c]^sb[4*c+1]^sb[4*c+2]^sb[4*c+3]) ^ xt(sb[4*c]^sb[4*c+1]);
			mc[4*c+1] = sb[4*c+1] ^ (sb[4*c]^sb[4*c+1]^sb[4*c+2]^sb[4*c+3]) ^ xt(sb[4*c+1]^sb[4*c+2]);
			mc[4*c+2] = sb[4*c+2] ^ (sb[4*c]^sb[4*c+1]^sb[4*c+2]^sb[4*c+3]) ^ xt(sb[4*c+2]^sb[4*c+3]);
			mc[4*c+3] = sb[4*c+3] ^ (sb[4*c]^sb[4*c+1]^sb[4*c+2]^sb[4*c+3]) ^ xt(sb[4*c+3]^sb[4*c]);
		end
		for (int i = 0; i < 16; i++)
			rnd_out[127 - 8*i -: 8] = (cmd.rk_round == 4'd11) ? sb[i] : mc[i];
	end

	logic [127:0] mask, res;
	always_comb begin
		for (int i = 0; i < 16; i++)
			mask[127 - 8*i -: 8] = ((i < 16 && 5'(i) < cnt_q) || cnt_q > 5'd16) ? 8'hff : 8'h00;
		res = data_q ^ (st_q & mask);
	end

	// one 128-bit round key per row, written once four words are ready
	always_ff @(posedge clk) begin
		if (cmd.exp_step && ei_q[1:0] == 2'd3)
			rk_mem[ei_q[5:2]] <= {w_q[1], w_q[2], w_q[3], rk_wr};
		if (cmd.rk_rd) rk_rd_q <= rk_mem[cmd.rk_round];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			data_q <= {data_high, data_low};
			cnt_q  <= byte_count;
		end
		if (cmd.gen_seed || cmd.gen_draw || cmd.gen_emit) begin
			g_q[0] <= g_q[1]; g_q[1] <= g_q[2]; g_q[2] <= g_q[3];
			g_q[3] <= cmd.gen_seed ? sn : dn;
		end
		if (cmd.gen_emit) begin
			if (cmd.derive) ctr_q <= {ctr_q[119:0], dn[31:24]};
			else            key_q <= {key_q[119:0], dn[31:24]};
		end
		if (cmd.exp_step) w_q <= '{w_q[1], w_q[2], w_q[3], rk_wr};
		if (cmd.round) begin
			if (cmd.rk_round == 4'd1) st_q <= ctr_q ^ rk_now;
			else st_q <= rnd_out ^ rk_now;
		end
		if (cmd.finish) begin
			ctr_q <= ctr_q + 128'd1;
			result_high  <= res[127:64];
			result_low   <= res[63:0];
			result_count <= cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gcnt_q    <= '0;
			ei_q      <= '0;
			kv_q      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (cmd.gen_clr) gcnt_q <= '0;
			else if (cmd.gen_seed || cmd.gen_draw || cmd.gen_emit) gcnt_q <= gcnt_q + 5'd1;
			if (cmd.exp_step) ei_q <= (ei_q == 6'(RK_WORDS - 1)) ? '0 : ei_q + 6'd1;
			if (cmd.exp_step) kv_q <= 1'b1;
			if (cmd.finish) out_valid <= 1'b1;
			else if (cmd.take_out) out_valid <= 1'b0;
		end
	end

	assign sts.need_derive = !kv_q;
	assign sts.gen_cnt     = gcnt_q;
	assign sts.exp_idx     = ei_q;
	assign sts.out_busy    = out_valid;

endmodule

// ----- sv/aes128_ctr_seeded_key_cipher.sv -----
// AES-128 counter-mode cipher with seeded key and counter.
// Input stream s_axis: one beat is one 16-byte block; tuser is the restart flag.
// Output stream m_axis: one beat per input beat, same order.
// Configuration: cfg_we/cfg_index/cfg_data write key_seed (0), key_rolls (1),
// counter_seed (2), counter_rolls (3); used at the next restart.
// Each block passes through load, round-key read, 11 round-key
// additions over one shared round unit and output hand-off; a new
// block is taken only in the idle state; m_axis_tvalid is registered.
// On restart, or the first beat after reset, key and counter derivation
// runs 4 seed words, 2*(rolls+1) draws and 16 bytes per generator, one
// per cycle, and expands 44 round-key words, one word per cycle.
// Reset clears control state; the first beat always derives keys.
// A stalled output holds its beat; the next block is taken meanwhile but
// finishes only after the held beat is taken.
module aes128_ctr_seeded_key_cipher
	import actr_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [135:0] s_axis_tdata,  // data_high, data_low, byte_count, pad
	input  logic         s_axis_tuser,  // restart
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [135:0] m_axis_tdata,  // result_high, result_low, result_count, pad
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	logic [31:0] key_seed_q, ctr_seed_q;
	logic [3:0]  key_rolls_q, ctr_rolls_q;
	cmd_t cmd;
	sts_t sts;
	logic [63:0] rh, rl;
	logic [4:0]  rc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_seed_q <= '0; key_rolls_q <= '0; ctr_seed_q <= '0; ctr_rolls_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_KEY_SEED:  key_seed_q  <= cfg_data;
				CFG_KEY_ROLLS: key_rolls_q <= cfg_data[3:0];
				CFG_CTR_SEED:  ctr_seed_q  <= cfg_data;
				CFG_CTR_ROLLS: ctr_rolls_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	actr_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_restart(s_axis_tuser), .in_ready(s_axis_tready),
		.out_ready(m_axis_tready), .key_rolls(key_rolls_q), .ctr_rolls(ctr_rolls_q),
		.sts, .cmd
	);

	actr_dp u_dp (
		.clk, .arst_n, .cmd, .sts,
		.key_seed(key_seed_q), .ctr_seed(ctr_seed_q),
		.data_high(s_axis_tdata[63:0]), .data_low(s_axis_tdata[127:64]),
		.byte_count(s_axis_tdata[132:128]),
		.out_valid(m_axis_tvalid), .result_high(rh), .result_low(rl), .result_count(rc)
	);

	assign m_axis_tdata = {3'b000, rc, rl, rh};

endmodule

// ----- bench/actr_checker.sv -----
module actr_checker
	import actr_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [135:0] s_axis_tdata,
	input  logic         s_axis_tuser,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [135:0] m_axis_tdata,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	output int           errors,
	output int           pending,
	output int           blocks_seen
);

	typedef struct packed {
		logic [63:0] hi;
		logic [63:0] lo;
		logic [4:0]  cnt;
	} cipher_out_t;

	localparam logic [7:0] SUBST [256] = '{
	8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
	8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
	8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
	8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
	8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
	8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
	8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
	8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
	8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
	8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
	8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
	8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
	8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
	8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
	8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
	8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

	logic [31:0]  key_seed, ctr_seed;
	logic [3:0]   key_rolls, ctr_rolls;
	logic [127:0] ctr;
	logic [31:0]  rk [44];
	logic         have_keys;
	cipher_out_t  expected_q [$];

	function automatic logic [31:0] sub_word(input logic [31:0] x);
		return {SUBST[x[31:24]], SUBST[x[23:16]], SUBST[x[15:8]], SUBST[x[7:0]]};
	endfunction

	function automatic logic [7:0] dbl(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] rcon_of(input int i);
		logic [7:0] c;
		c = 8'h01;
		for (int j = 0; j < i; j++)
			c = dbl(c);
		return c;
	endfunction

	// xorshift128 seeded by the 0x6C078965 recurrence; byte 0 ends up in bits 127:120
	function automatic logic [127:0] seeded_bytes(input logic [31:0] seed, input logic [3:0] rolls);
		logic [31:0]  w [4];
		logic [31:0]  p, t, d;
		logic [127:0] r;
		int           n;
		p = seed;
		for (int i = 0; i < 4; i++) begin
			p = GEN_MULT * (p ^ (p >> 30)) + 32'(i + 1);
			w[i] = p;
		end
		n = 2 * (int'(rolls) + 1);
		r = '0;
		for (int i = 0; i < n + 16; i++) begin
			t = w[0];
			d = w[3];
			w[0] = w[1];
			w[1] = w[2];
			w[2] = d;
			t ^= t << 11;
			t ^= t >> 8;
			w[3] = t ^ d ^ (d >> 19);
			if (i >= n)
				r = {r[119:0], w[3][31:24]};
		end
		return r;
	endfunction

	task automatic derive_keys();
		logic [127:0] k;
		logic [31:0]  t;
		k = seeded_bytes(key_seed, key_rolls);
		ctr = seeded_bytes(ctr_seed, ctr_rolls);
		for (int i = 0; i < 4; i++)
			rk[i] = k[127 - 32 * i -: 32];
		for (int i = 4; i < 44; i++) begin
			t = rk[i - 1];
			if (i % 4 == 0)
				t = sub_word({t[23:0], t[31:24]}) ^ {rcon_of(i / 4 - 1), 24'h0};
			rk[i] = rk[i - 4] ^ t;
		end
		have_keys = 1'b1;
	endtask

	function automatic logic [127:0] keystream(input logic [127:0] blk);
		logic [7:0] s [16];
		logic [7:0] u [16];
		logic [7:0] a, b, c, e, x;
		logic [127:0] r;
		for (int i = 0; i < 16; i++)
			s[i] = blk[127 - 8 * i -: 8] ^ rk[i / 4][31 - 8 * (i % 4) -: 8];
		for (int rd = 1; rd <= 10; rd++) begin
			for (int cc = 0; cc < 4; cc++)
				for (int rr = 0; rr < 4; rr++)
					u[4 * cc + rr] = SUBST[s[4 * ((cc + rr) % 4) + rr]];
			s = u;
			if (rd < 10)
				for (int cc = 0; cc < 4; cc++) begin
					a = s[4 * cc]; b = s[4 * cc + 1]; c = s[4 * cc + 2]; e = s[4 * cc + 3];
					x = a ^ b ^ c ^ e;
					s[4 * cc]     ^= x ^ dbl(a ^ b);
					s[4 * cc + 1] ^= x ^ dbl(b ^ c);
					s[4 * cc + 2] ^= x ^ dbl(c ^ e);
					s[4 * cc + 3] ^= x ^ dbl(e ^ a);
				end
			for (int i = 0; i < 16; i++)
				s[i] ^= rk[4 * rd + i / 4][31 - 8 * (i % 4) -: 8];
		end
		for (int i = 0; i < 16; i++)
			r[127 - 8 * i -: 8] = s[i];
		return r;
	endfunction

	function automatic cipher_out_t predict_block(input logic [135:0] d);
		logic [127:0] ks, msk;
		int           n;
		cipher_out_t  o;
		n = (d[132:128] > 16) ? 16 : int'(d[132:128]);
		ks = keystream(ctr);
		msk = '0;
		for (int i = 0; i < n; i++)
			msk[127 - 8 * i -: 8] = ks[127 - 8 * i -: 8];
		o.hi = d[63:0] ^ msk[127:64];
		o.lo = d[127:64] ^ msk[63:0];
		o.cnt = d[132:128];
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		cipher_out_t e, g;
		if (!arst_n) begin
			key_seed <= '0;
			key_rolls <= '0;
			ctr_seed <= '0;
			ctr_rolls <= '0;
			have_keys = 1'b0;
			ctr = '0;
			expected_q.delete();
			errors = 0;
			blocks_seen = 0;
		end else begin
			if (cfg_we)
				case (cfg_idx_t'(cfg_index))
					CFG_KEY_SEED:  key_seed <= cfg_data;
					CFG_KEY_ROLLS: key_rolls <= cfg_data[3:0];
					CFG_CTR_SEED:  ctr_seed <= cfg_data;
					CFG_CTR_ROLLS: ctr_rolls <= cfg_data[3:0];
				endcase
			if (s_axis_tvalid && s_axis_tready) begin
				if (s_axis_tuser || !have_keys)
					derive_keys();
				expected_q = {expected_q, predict_block(s_axis_tdata)};
				ctr = ctr + 128'd1;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				blocks_seen++;
				g.hi = m_axis_tdata[63:0];
				g.lo = m_axis_tdata[127:64];
				g.cnt = m_axis_tdata[132:128];
				if (expected_q.size() == 0) begin
					$error("output beat with nothing expected: %h", m_axis_tdata);
					errors++;
				end else begin
					e = expected_q.pop_front();
					if (g.hi !== e.hi) begin
						$error("result_high expected %h actual %h", e.hi, g.hi);
						errors++;
					end
					if (g.lo !== e.lo) begin
						$error("result_low expected %h actual %h", e.lo, g.lo);
						errors++;
					end
					if (g.cnt !== e.cnt) begin
						$error("result_count expected %0d actual %0d", e.cnt, g.cnt);
						errors++;
					end
				end
			end
		end
		pending = expected_q.size();
	end

endmodule

// ----- bench/tb_aes128_ctr_seeded_key_cipher.sv -----
module tb_aes128_ctr_seeded_key_cipher
	import actr_pkg::*;
();

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [135:0] s_axis_tdata;   // data_high, data_low, byte_count, pad
	logic         s_axis_tuser;   // restart
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [135:0] m_axis_tdata;   // result_high, result_low, result_count, pad
	logic         cfg_we;
	logic [1:0]   cfg_index;
	logic [31:0]  cfg_data;
	int           errors, pending, blocks_seen;
	int           idle_cycles;
	int           restarts;
	bit           long_hold;
	bit           hold_done;

	aes128_ctr_seeded_key_cipher uut (.*);

	actr_checker chk (.*);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// receiver: rotating stall patterns, plus one long hold-off on request
	initial begin
		int mode;
		m_axis_tready = 1'b0;
		mode = 0;
		forever begin
			@(negedge clk);
			if (long_hold && !hold_done) begin
				m_axis_tready = 1'b0;
				repeat (300) @(negedge clk);
				hold_done = 1'b1;
			end
			if ($urandom_range(63) == 0)
				mode = $urandom_range(3);
			case (mode)
				0: m_axis_tready = 1'b1;
				1: m_axis_tready = $urandom_range(1);
				2: m_axis_tready = ($urandom_range(7) == 0);
				default: m_axis_tready = ($urandom_range(7) != 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 3000) begin
			$display("tb_aes128_ctr_seeded_key_cipher: errors");
			$finish;
		end
	end

	task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic set_config(input logic [31:0] ks, kr, cs, cr);
		write_reg(CFG_KEY_SEED, ks);
		write_reg(CFG_KEY_ROLLS, kr);
		write_reg(CFG_CTR_SEED, cs);
		write_reg(CFG_CTR_ROLLS, cr);
	endtask

	// leaves tvalid high after the beat is taken; caller decides on a gap
	task automatic send_block(input logic rs, input logic [63:0] hi, lo, input logic [4:0] n);
		@(negedge clk);
		s_axis_tvalid = 1'b1;
		s_axis_tuser = rs;
		s_axis_tdata = {3'b0, n, lo, hi};
		restarts += rs;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic gap();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		repeat ($urandom_range(6)) @(negedge clk);
	endtask

	task automatic drain();
		while (pending != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	function automatic logic [4:0] rand_count();
		int r;
		r = $urandom_range(9);
		if (r < 6) return 5'd16;
		if (r < 8) return 5'($urandom_range(1, 16));
		return 5'($urandom_range(31));
	endfunction

	task automatic random_phase(input int items, input bit with_hold);
		int burst;
		burst = 0;
		for (int i = 0; i < items; i++) begin
			if (with_hold && i == 20)
				long_hold = 1'b1;
			send_block(i == 0 || $urandom_range(24) == 0,
				{$urandom, $urandom}, {$urandom, $urandom}, rand_count());
			if (burst == 0) begin
				gap();
				burst = $urandom_range(1, 3) == 1 ? 40 : $urandom_range(1, 8);
			end else
				burst--;
		end
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		drain();
	endtask

	initial begin
		logic [4:0] cnts [10];
		cnts = '{5'd0, 5'd1, 5'd7, 5'd8, 5'd9, 5'd15, 5'd16, 5'd17, 5'd31, 5'd16};
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tuser = 1'b0;
		s_axis_tdata = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_KEY_SEED;
		cfg_data = '0;
		long_hold = 1'b0;
		hold_done = 1'b0;
		restarts = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset values, first block derives without restart flag
		for (int i = 0; i < 10; i++)
			send_block(1'b0, (i % 2) ? '1 : '0, (i % 2) ? '0 : '1, cnts[i]);
		send_block(1'b1, 64'h0123456789abcdef, 64'hfedcba9876543210, 5'd16);
		gap();
		drain();

		set_config('1, 32'hf, '1, 32'hf);
		send_block(1'b1, '1, '1, 5'd16);
		send_block(1'b0, '0, '0, 5'd0);
		send_block(1'b0, '1, '1, 5'd31);
		send_block(1'b1, 64'haaaa5555aaaa5555, 64'h5555aaaa5555aaaa, 5'd3);
		gap();
		drain();

		set_config('0, '0, '1, '0);
		random_phase(180, 1'b0);
		set_config($urandom, $urandom, $urandom, $urandom);
		random_phase(220, 1'b1);
		set_config(32'h80000000, 32'h7, 32'h00000001, 32'h8);
		random_phase(200, 1'b0);
		set_config($urandom, $urandom, $urandom, $urandom);
		random_phase(230, 1'b0);
		set_config($urandom, 32'hf, $urandom, 32'h0);
		random_phase(200, 1'b0);

		$display("covered %0d output blocks, %0d restarts, seven register settings", blocks_seen,
			restarts);
		$display("byte counts 0..31, long output stall applied: %0d", hold_done);
		if (errors == 0)
			$display("tb_aes128_ctr_seeded_key_cipher: clean");
		else
			$display("tb_aes128_ctr_seeded_key_cipher: errors");
		$finish;
	end

endmodule

// ----- aes128_ctr_seeded_key_cipher.f -----
sv/actr_pkg.sv
sv/actr_ctrl.sv
sv/actr_dp.sv
sv/aes128_ctr_seeded_key_cipher.sv
bench/actr_checker.sv
bench/tb_aes128_ctr_seeded_key_cipher.sv
